// ===== sv/osn_pkg.sv =====
// Shared types, constants and helper functions of the octave simplex noise unit.
`timescale 1ns / 1ps

package osn_pkg;

    // Block dimensions
    localparam int TABLE_DEPTH = 256;
    localparam int TAB_AW      = $clog2(TABLE_DEPTH);
    localparam int MAX_OCTAVES = 8;
    localparam int COORD_BITS  = 16;
    localparam int OCT_W       = $clog2(MAX_OCTAVES + 1);

    // Fixed-point constants (Q0.16) and the integer noise gain
    localparam int SKEW_Q16   = 23988;
    localparam int UNSKEW_Q16 = 13850;
    localparam int NOISE_GAIN = 70;

    // Datapath widths
    localparam int FREQ_W  = 16 + MAX_OCTAVES - 1;      // base_scale << octave
    localparam int PX_W    = COORD_BITS + FREQ_W + 1;   // Q.16 point
    localparam int S_W     = PX_W + 1;                  // px + py and skew term
    localparam int SKP_W   = S_W + 17;                  // skew product
    localparam int CS_W    = S_W + 1;                   // px + s
    localparam int CELL_W  = CS_W - 16;                 // cell index
    localparam int TT_W    = CELL_W + 17;               // unskew term
    localparam int OW_W    = TT_W + 1;                  // wide offset sum
    // Cell offset Q.16; the rounded skew and unskew constants drift apart far
    // from the origin, so the offset can reach several million
    localparam int OFF_W   = 26;
    localparam int COFF_W  = OFF_W + 1;                 // corner offset Q.16
    localparam int SQ_W    = 2 * COFF_W;                // offset square Q.32
    localparam int TV_W    = SQ_W + 2;                  // falloff Q.32
    localparam int T2_W    = 30;
    localparam int T4_W    = 28;
    localparam int DOT_W   = COFF_W + 2;
    localparam int TM_W    = T4_W + 1 + DOT_W;          // corner term Q.48
    localparam int SUM_W   = TM_W + 2;
    localparam int SC_W    = SUM_W + 8;
    localparam int NV_W    = 30;                        // octave noise Q.20
    localparam int WT_W    = 16 + MAX_OCTAVES - 1;      // octave weight Q.15
    localparam int WP_W    = WT_W + 16;
    localparam int WSUM_W  = WT_W + 1;
    localparam int DIVR_W  = WSUM_W + 5;                // 32 * weight sum
    localparam int REM_W   = DIVR_W + 1;
    localparam int ACC_W   = NV_W + WT_W + 1 + $clog2(MAX_OCTAVES + 1);
    localparam int CNT_W   = $clog2(ACC_W + 1);
    localparam int OUT_W   = 16;
    localparam int SEL_W   = 3;

    // Input item kinds
    typedef enum logic {
        OPC_LOAD   = 1'b0,
        OPC_SAMPLE = 1'b1
    } opcode_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_OCT_COUNT  = 2'd0,
        REG_ROUGHNESS  = 2'd1,
        REG_BASE_SCALE = 2'd2
    } cfg_reg_t;

    // Corner and hash step selectors
    localparam logic [SEL_W-1:0] SEL_LAST_READ   = 3'd5;
    localparam logic [SEL_W-1:0] SEL_LAST_CORNER = 3'd2;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NONE, OP_START, OP_PT, OP_SKEW, OP_CELL, OP_UNSKEW, OP_OFF,
        OP_RD, OP_CAP, OP_SQ, OP_T2, OP_T4, OP_TERM, OP_SCALE, OP_ACC,
        OP_WT, OP_DINIT, OP_DIV, OP_SIGN, OP_OUT
    } dp_op_t;

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE, ST_PT, ST_SKEW, ST_CELL, ST_UNSKEW, ST_OFF, ST_RD, ST_CAP,
        ST_SQ, ST_T2, ST_T4, ST_TERM, ST_SCALE, ST_ACC, ST_WT, ST_DINIT,
        ST_DIV, ST_SIGN, ST_DONE
    } state_t;

    typedef struct packed {
        dp_op_t           op;
        logic [SEL_W-1:0] sel;
    } osn_cmd_t;

    typedef struct packed {
        logic last_octave;
        logic div_last;
        logic out_free;
    } osn_status_t;

    // Table byte modulo twelve
    function automatic logic [3:0] mod12(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if (r >= 8'd192) r = r - 8'd192;
        if (r >= 8'd96)  r = r - 8'd96;
        if (r >= 8'd48)  r = r - 8'd48;
        if (r >= 8'd24)  r = r - 8'd24;
        if (r >= 8'd12)  r = r - 8'd12;
        return r[3:0];
    endfunction

    // Gradient x component: 2'b01 plus one, 2'b11 minus one, 2'b00 zero
    function automatic logic [1:0] grad_x(input logic [3:0] g);
        if (g < 4'd8) return g[0] ? 2'b11 : 2'b01;
        return 2'b00;
    endfunction

    // Gradient y component
    function automatic logic [1:0] grad_y(input logic [3:0] g);
        if (g < 4'd4) return g[1] ? 2'b11 : 2'b01;
        if (g < 4'd8) return 2'b00;
        return g[0] ? 2'b11 : 2'b01;
    endfunction

endpackage

// ===== sv/osn_ctrl.sv =====
// Sequencer that steps the noise datapath through octaves, corners and the divide.
`timescale 1ns / 1ps

module osn_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tuser,
    input  osn_pkg::osn_status_t status,
    output logic                 s_tready,
    output osn_pkg::osn_cmd_t    cmd
);
    import osn_pkg::*;

    state_t           state_reg, state_next;
    logic [SEL_W-1:0] sel_reg, sel_next;

    // State and selector registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            sel_reg   <= '0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid && s_tuser == OPC_SAMPLE) state_next = ST_PT;
            ST_PT:     state_next = ST_SKEW;
            ST_SKEW:   state_next = ST_CELL;
            ST_CELL:   state_next = ST_UNSKEW;
            ST_UNSKEW: state_next = ST_OFF;
            ST_OFF: begin
                state_next = ST_RD;
                sel_next   = '0;
            end
            ST_RD:     state_next = ST_CAP;
            ST_CAP: begin
                if (sel_reg == SEL_LAST_READ) begin
                    state_next = ST_SQ;
                    sel_next   = '0;
                end else begin
                    state_next = ST_RD;
                    sel_next   = sel_reg + 1'b1;
                end
            end
            ST_SQ:     state_next = ST_T2;
            ST_T2:     state_next = ST_T4;
            ST_T4:     state_next = ST_TERM;
            ST_TERM: begin
                if (sel_reg == SEL_LAST_CORNER) begin
                    state_next = ST_SCALE;
                end else begin
                    state_next = ST_SQ;
                    sel_next   = sel_reg + 1'b1;
                end
            end
            ST_SCALE:  state_next = ST_ACC;
            ST_ACC:    state_next = ST_WT;
            ST_WT:     state_next = status.last_octave ? ST_DINIT : ST_PT;
            ST_DINIT:  state_next = ST_DIV;
            ST_DIV:    if (status.div_last) state_next = ST_SIGN;
            ST_SIGN:   state_next = ST_DONE;
            ST_DONE:   if (status.out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd.sel  = sel_reg;
        cmd.op   = OP_NONE;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && s_tuser == OPC_SAMPLE) cmd.op = OP_START;
            end
            ST_PT:     cmd.op = OP_PT;
            ST_SKEW:   cmd.op = OP_SKEW;
            ST_CELL:   cmd.op = OP_CELL;
            ST_UNSKEW: cmd.op = OP_UNSKEW;
            ST_OFF:    cmd.op = OP_OFF;
            ST_RD:     cmd.op = OP_RD;
            ST_CAP:    cmd.op = OP_CAP;
            ST_SQ:     cmd.op = OP_SQ;
            ST_T2:     cmd.op = OP_T2;
            ST_T4:     cmd.op = OP_T4;
            ST_TERM:   cmd.op = OP_TERM;
            ST_SCALE:  cmd.op = OP_SCALE;
            ST_ACC:    cmd.op = OP_ACC;
            ST_WT:     cmd.op = OP_WT;
            ST_DINIT:  cmd.op = OP_DINIT;
            ST_DIV:    cmd.op = OP_DIV;
            ST_SIGN:   cmd.op = OP_SIGN;
            ST_DONE:   if (status.out_free) cmd.op = OP_OUT;
            default:   cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== sv/osn_datapath.sv =====
// Noise datapath: permutation memory, fixed-point octave arithmetic, divider, output register.
`timescale 1ns / 1ps

module osn_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_addr,
    input  logic [15:0]          cfg_wr_data,
    input  logic                 s_accept,
    input  logic                 s_tuser,
    input  logic [47:0]          s_tdata,
    input  osn_pkg::osn_cmd_t    cmd,
    output osn_pkg::osn_status_t status,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [15:0]          m_tdata
);
    import osn_pkg::*;

    localparam logic signed [TV_W-1:0]  HALF_Q32   = TV_W'(64'sd2147483648);
    localparam logic signed [SC_W-1:0]  ROUND_Q28  = SC_W'(64'sd134217728);
    localparam logic signed [SKP_W-1:0] ROUND_Q16  = SKP_W'(64'sd32768);
    localparam logic signed [COFF_W-1:0] ONE_Q16   = COFF_W'(64'sd65536);
    localparam logic signed [COFF_W-1:0] G2_Q16    = COFF_W'(UNSKEW_Q16);

    // Configuration registers
    logic [3:0]  oct_count_reg;
    logic [15:0] roughness_reg;
    logic [15:0] base_scale_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oct_count_reg  <= 4'd1;
            roughness_reg  <= 16'd32768;
            base_scale_reg <= 16'd655;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_OCT_COUNT:  oct_count_reg  <= cfg_wr_data[3:0];
                REG_ROUGHNESS:  roughness_reg  <= cfg_wr_data;
                REG_BASE_SCALE: base_scale_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Permutation memory
    logic [7:0]        perm_mem [TABLE_DEPTH];
    logic [7:0]        rd_reg;
    logic [TAB_AW-1:0] rd_addr;

    always_ff @(posedge aclk) begin
        if (s_accept && s_tuser == OPC_LOAD) perm_mem[s_tdata[7:0]] <= s_tdata[15:8];
        rd_reg <= perm_mem[rd_addr];
    end

    // Working registers
    logic signed [COORD_BITS-1:0] x_reg, y_reg;
    logic [FREQ_W-1:0]            freq_reg;
    logic [OCT_W-1:0]             oct_reg;
    logic signed [PX_W-1:0]       px_reg, py_reg;
    logic signed [S_W-1:0]        s_reg;
    logic signed [CELL_W-1:0]     ci_reg, cj_reg;
    logic signed [TT_W-1:0]       t_reg;
    logic signed [OFF_W-1:0]      x0_reg, y0_reg;
    logic                         i1_reg;
    logic [7:0]                   p_reg [3];
    logic [3:0]                   g_reg [3];
    logic signed [TV_W-1:0]       fall_reg;
    logic signed [DOT_W-1:0]      dot_reg;
    logic [T2_W-1:0]              t2_reg;
    logic [T4_W-1:0]              t4_reg;
    logic signed [SUM_W-1:0]      sum_reg;
    logic signed [NV_W-1:0]       nv_reg;
    logic signed [ACC_W-1:0]      acc_reg;
    logic [WT_W-1:0]              wt_reg;
    logic [WSUM_W-1:0]            wsum_reg;
    logic [ACC_W-1:0]             quo_reg;
    logic [REM_W-1:0]             rem_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic                         neg_reg;
    logic [OUT_W-1:0]             res_reg;
    logic [OUT_W-1:0]             m_tdata_reg;
    logic                         m_tvalid_reg;

    // Octave count clamped to one through the maximum
    logic [3:0] oct_n;
    always_comb begin
        oct_n = oct_count_reg;
        if (oct_count_reg == 4'd0) oct_n = 4'd1;
        if (oct_count_reg > 4'(MAX_OCTAVES)) oct_n = 4'(MAX_OCTAVES);
    end

    // Hash addresses
    logic j1;
    assign j1 = ~i1_reg;
    always_comb begin
        unique case (cmd.sel)
            3'd0:    rd_addr = cj_reg[TAB_AW-1:0];
            3'd1:    rd_addr = cj_reg[TAB_AW-1:0] + TAB_AW'(j1);
            3'd2:    rd_addr = cj_reg[TAB_AW-1:0] + 1'b1;
            3'd3:    rd_addr = ci_reg[TAB_AW-1:0] + p_reg[0];
            3'd4:    rd_addr = ci_reg[TAB_AW-1:0] + TAB_AW'(i1_reg) + p_reg[1];
            3'd5:    rd_addr = ci_reg[TAB_AW-1:0] + 1'b1 + p_reg[2];
            default: rd_addr = cj_reg[TAB_AW-1:0];
        endcase
    end

    // Corner offsets and gradient
    logic signed [COFF_W-1:0] x0e, y0e, cx, cy;
    logic [3:0]               gsel;
    logic [1:0]               gx, gy;
    always_comb begin
        x0e = COFF_W'(x0_reg);
        y0e = COFF_W'(y0_reg);
        unique case (cmd.sel)
            3'd0: begin
                cx = x0e;
                cy = y0e;
                gsel = g_reg[0];
            end
            3'd1: begin
                cx = x0e - (i1_reg ? ONE_Q16 : '0) + G2_Q16;
                cy = y0e - (j1 ? ONE_Q16 : '0) + G2_Q16;
                gsel = g_reg[1];
            end
            default: begin
                cx = x0e - ONE_Q16 + G2_Q16 + G2_Q16;
                cy = y0e - ONE_Q16 + G2_Q16 + G2_Q16;
                gsel = g_reg[2];
            end
        endcase
        gx = grad_x(gsel);
        gy = grad_y(gsel);
    end

    // Step arithmetic
    logic signed [PX_W-1:0]   px_m, py_m, fr_e;
    logic signed [SKP_W-1:0]  sk_p;
    logic signed [CS_W-1:0]   csx, csy;
    logic signed [TT_W-1:0]   ij_e;
    logic signed [OW_W-1:0]   x0w, y0w;
    logic signed [SQ_W-1:0]   sqx, sqy;
    logic signed [DOT_W-1:0]  dx, dy;
    logic [61:0]              t2p;
    logic [59:0]              t4p;
    logic signed [TM_W-1:0]   term;
    logic signed [SC_W-1:0]   scl;
    logic signed [ACC_W-1:0]  prod_acc;
    logic [WP_W-1:0]          wprod;
    logic [ACC_W-1:0]         mag;
    logic [REM_W:0]           trial;
    logic [OUT_W:0]           sat;

    always_comb begin
        fr_e  = PX_W'({1'b0, freq_reg});
        px_m  = PX_W'(x_reg) * fr_e;
        py_m  = PX_W'(y_reg) * fr_e;
        sk_p  = (SKP_W'(px_reg) + SKP_W'(py_reg)) * SKP_W'(SKEW_Q16) + ROUND_Q16;
        csx   = CS_W'(px_reg) + CS_W'(s_reg);
        csy   = CS_W'(py_reg) + CS_W'(s_reg);
        ij_e  = (TT_W'(ci_reg) + TT_W'(cj_reg)) * TT_W'(UNSKEW_Q16);
        x0w   = OW_W'(px_reg) - (OW_W'(ci_reg) <<< 16) + OW_W'(t_reg);
        y0w   = OW_W'(py_reg) - (OW_W'(cj_reg) <<< 16) + OW_W'(t_reg);
        sqx   = SQ_W'(cx) * SQ_W'(cx);
        sqy   = SQ_W'(cy) * SQ_W'(cy);
        dx    = (gx == 2'b01) ? DOT_W'(cx) : (gx == 2'b11) ? -DOT_W'(cx) : '0;
        dy    = (gy == 2'b01) ? DOT_W'(cy) : (gy == 2'b11) ? -DOT_W'(cy) : '0;
        t2p   = 62'(fall_reg[30:0]) * 62'(fall_reg[30:0]);
        t4p   = 60'(t2_reg) * 60'(t2_reg);
        term  = TM_W'($signed({1'b0, t4_reg})) * TM_W'(dot_reg);
        scl   = SC_W'(sum_reg) * SC_W'(NOISE_GAIN) + ROUND_Q28;
        prod_acc = ACC_W'(nv_reg) * ACC_W'({1'b0, wt_reg});
        wprod = WP_W'(wt_reg) * WP_W'(roughness_reg);
        mag   = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        trial = {rem_reg, quo_reg[ACC_W-1]} - (REM_W+1)'({wsum_reg, 5'b0});
        // Saturate quotient magnitude with its sign
        if (neg_reg) begin
            sat = (quo_reg > ACC_W'(32768)) ? 17'h08000 : -(OUT_W+1)'(quo_reg[OUT_W:0]);
        end else begin
            sat = (quo_reg > ACC_W'(32767)) ? 17'h07FFF : quo_reg[OUT_W:0];
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_START: begin
                x_reg    <= s_tdata[31:16];
                y_reg    <= s_tdata[47:32];
                freq_reg <= FREQ_W'(base_scale_reg);
                oct_reg  <= '0;
                acc_reg  <= '0;
                wt_reg   <= WT_W'(32768);
                wsum_reg <= '0;
            end
            OP_PT: begin
                px_reg <= px_m;
                py_reg <= py_m;
            end
            OP_SKEW:   s_reg <= S_W'(sk_p >>> 16);
            OP_CELL: begin
                ci_reg <= CELL_W'(csx >>> 16);
                cj_reg <= CELL_W'(csy >>> 16);
            end
            OP_UNSKEW: t_reg <= ij_e;
            OP_OFF: begin
                x0_reg  <= OFF_W'(x0w);
                y0_reg  <= OFF_W'(y0w);
                i1_reg  <= (OFF_W'(x0w) > OFF_W'(y0w));
                sum_reg <= '0;
            end
            OP_CAP: begin
                if (cmd.sel < 3'd3) p_reg[cmd.sel[1:0]] <= rd_reg;
                else if (cmd.sel == 3'd3) g_reg[0] <= mod12(rd_reg);
                else if (cmd.sel == 3'd4) g_reg[1] <= mod12(rd_reg);
                else g_reg[2] <= mod12(rd_reg);
            end
            OP_SQ: begin
                fall_reg <= HALF_Q32 - TV_W'(sqx) - TV_W'(sqy);
                dot_reg  <= dx + dy;
            end
            OP_T2:    t2_reg  <= (fall_reg > 0) ? T2_W'(t2p >> 32) : '0;
            OP_T4:    t4_reg  <= T4_W'(t4p >> 32);
            OP_TERM:  sum_reg <= sum_reg + SUM_W'(term);
            OP_SCALE: nv_reg  <= NV_W'(scl >>> 28);
            OP_ACC: begin
                acc_reg  <= acc_reg + prod_acc;
                wsum_reg <= wsum_reg + WSUM_W'(wt_reg);
            end
            OP_WT: begin
                wt_reg   <= WT_W'(wprod >> 15);
                freq_reg <= freq_reg << 1;
                oct_reg  <= oct_reg + 1'b1;
            end
            OP_DINIT: begin
                quo_reg <= mag;
                rem_reg <= '0;
                cnt_reg <= CNT_W'(ACC_W);
                neg_reg <= acc_reg[ACC_W-1];
            end
            // One restoring quotient bit a cycle
            OP_DIV: begin
                if (!trial[REM_W]) rem_reg <= trial[REM_W-1:0];
                else rem_reg <= {rem_reg[REM_W-2:0], quo_reg[ACC_W-1]};
                quo_reg <= {quo_reg[ACC_W-2:0], ~trial[REM_W]};
                cnt_reg <= cnt_reg - 1'b1;
            end
            OP_SIGN: res_reg     <= sat[OUT_W-1:0];
            OP_OUT:  m_tdata_reg <= res_reg;
            default: ;
        endcase
    end

    // Output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.op == OP_OUT) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign status.last_octave = ({1'b0, oct_reg} == 5'(oct_n) - 5'd1);
    assign status.div_last    = (cnt_reg == CNT_W'(1));
    assign status.out_free    = ~m_tvalid_reg | m_tready;
    assign m_tvalid           = m_tvalid_reg;
    assign m_tdata            = m_tdata_reg;

endmodule

// ===== sv/octave_simplex_noise_2d_unit.sv =====
// Top level of the fractal 2D simplex noise unit: controller plus datapath.
// A load transfer (tuser 0) writes one permutation byte and gives no result; the
// table must be fully loaded before samples. A sample transfer (tuser 1) raises
// m_tvalid once all N octaves and the final weighted average are done: each
// octave runs eight arithmetic steps, six reads of the permutation memory, each
// an address step and a capture step, and three four-step corner evaluations,
// and the final weighted average runs in a restoring divider that resolves one
// quotient bit a cycle. Samples are processed one at a time; a finished result
// waits in the output register while the next transfer is accepted, and a
// second finished result stalls until it drains.
`timescale 1ns / 1ps

module octave_simplex_noise_2d_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // table_index[7:0], table_value[15:8], coord_x[31:16], coord_y[47:32]
    input  logic        s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // noise_value[15:0]
);
    import osn_pkg::*;

    osn_cmd_t    cmd;
    osn_status_t status;

    osn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    osn_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_accept    (s_tvalid & s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .cmd         (cmd),
        .status      (status),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata)
    );

endmodule

// ===== sv/osn_checker.sv =====
// Port-level assertions for the noise unit and their bind to the top level.
`timescale 1ns / 1ps

module osn_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    // A stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A sample transfer closes the input until its work is done
    a_busy_after_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("input open right after a sample transfer");

    // No result appears in the cycle after a sample starts on an empty output
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
endmodule

bind octave_simplex_noise_2d_unit osn_checker u_osn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== verif/octave_simplex_noise_2d_unit_tb.sv =====
// Self-checking testbench for the octave simplex noise unit: table loads, directed and random samples.
`timescale 1ns / 1ps

module octave_simplex_noise_2d_unit_tb;
    import osn_pkg::*;

    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 400;
    localparam int WATCHDOG_MAX  = 20000;
    localparam int RANDOM_PHASE  = 35;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;    // table_index[7:0], table_value[15:8], coord_x[31:16], coord_y[47:32]
    logic        s_tuser;    // opcode
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // noise_value[15:0]

    octave_simplex_noise_2d_unit dut (.*);

    // Gradient directions
    localparam int GRAD_DX[12] = '{1, -1, 1, -1, 1, -1, 1, -1, 0, 0, 0, 0};
    localparam int GRAD_DY[12] = '{1, 1, -1, -1, 0, 0, 0, 0, 1, -1, 1, -1};

    // Mirror of the block's table and registers
    logic [7:0]  perm_mem [TABLE_DEPTH];
    logic [3:0]  octaves_reg;
    logic [15:0] rough_reg;
    logic [15:0] scale_reg;

    logic [15:0] noise_q [$];
    int          err_count;
    int          samples_sent;
    int          loads_sent;
    int          results_seen;
    bit          no_idle;
    bit          hold_req;

    typedef struct {
        opcode_t     opc;
        logic [7:0]  idx;
        logic [7:0]  val;
        logic [15:0] x;
        logic [15:0] y;
        bit          known;
        logic [15:0] noise;
    } stim_row_t;

    // Falloff-weighted gradient contribution of one corner, Q.48
    function automatic longint corner_term(longint cx, longint cy, int g);
        longint t, t2, t4, dotp;
        t = 64'sd2147483648 - cx * cx - cy * cy;
        if (t <= 0) return 0;
        t2 = (t * t) >>> 32;
        t4 = (t2 * t2) >>> 32;
        dotp = GRAD_DX[g] * cx + GRAD_DY[g] * cy;
        return t4 * dotp;
    endfunction

    function automatic int perm_rd(longint a);
        return int'(perm_mem[a & 255]);
    endfunction

    // Noise of one octave for a Q.16 point, Q.20
    function automatic longint cell_noise(longint px, longint py);
        longint u, hi, lo, s, i, j, t, x0, y0, x1, y1, x2, y2, ii, jj, sum;
        int i1, j1, g0, g1, g2;
        u  = px + py;
        hi = u >>> 16;
        lo = u - hi * 65536;
        s  = hi * SKEW_Q16 + ((lo * SKEW_Q16 + 32768) >>> 16);
        i  = (px + s) >>> 16;
        j  = (py + s) >>> 16;
        t  = (i + j) * UNSKEW_Q16;
        x0 = px - i * 65536 + t;
        y0 = py - j * 65536 + t;
        i1 = (x0 > y0) ? 1 : 0;
        j1 = 1 - i1;
        x1 = x0 - i1 * 65536 + UNSKEW_Q16;
        y1 = y0 - j1 * 65536 + UNSKEW_Q16;
        x2 = x0 - 65536 + 2 * UNSKEW_Q16;
        y2 = y0 - 65536 + 2 * UNSKEW_Q16;
        ii = i & 255;
        jj = j & 255;
        g0 = perm_rd(ii + perm_rd(jj)) % 12;
        g1 = perm_rd(ii + i1 + perm_rd(jj + j1)) % 12;
        g2 = perm_rd(ii + 1 + perm_rd(jj + 1)) % 12;
        sum = corner_term(x0, y0, g0) + corner_term(x1, y1, g1) + corner_term(x2, y2, g2);
        return (70 * sum + (64'sd1 << 27)) >>> 28;
    endfunction

    // Weighted octave sum, normalized and saturated to Q1.15
    function automatic logic [15:0] predict_noise(logic [15:0] xr, logic [15:0] yr);
        longint x, y, acc, wsum, weight, q, freq;
        int n;
        x = longint'($signed(xr));
        y = longint'($signed(yr));
        acc = 0;
        wsum = 0;
        weight = 32768;
        n = octaves_reg;
        if (n == 0) n = 1;
        if (n > MAX_OCTAVES) n = MAX_OCTAVES;
        for (int k = 0; k < n; k++) begin
            freq = longint'(scale_reg) << k;
            acc += cell_noise(x * freq, y * freq) * weight;
            wsum += weight;
            weight = (weight * longint'(rough_reg)) >>> 15;
        end
        q = acc / (wsum * 32);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: stop when nothing moves for too long
    int stuck_cycles;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles > WATCHDOG_MAX) begin
            $display("Timeout at %0t: no transfer for %0d cycles", $time, stuck_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: check each transfer, stall at random, hold off on request
    initial begin
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (noise_q.size() == 0) begin
                    $display("%0t: unexpected result %0d", $time, $signed(m_tdata));
                    err_count++;
                end else begin
                    if (m_tdata !== noise_q[0]) begin
                        $display("%0t: noise_value mismatch expected %0d actual %0d",
                                 $time, $signed(noise_q[0]), $signed(m_tdata));
                        err_count++;
                    end
                    void'(noise_q.pop_front());
                end
            end
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end else if (!no_idle && $urandom_range(3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one item, wait for its transfer, then update the mirror
    task automatic send_item(opcode_t opc, logic [7:0] idx, logic [7:0] val,
                             logic [15:0] x, logic [15:0] y, bit known, logic [15:0] noise);
        if (!no_idle && $urandom_range(3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= opc;
        s_tdata  <= {y, x, val, idx};
        do @(posedge aclk); while (!s_tready);
        if (opc == OPC_LOAD) begin
            perm_mem[idx] = val;
            loads_sent++;
        end else begin
            noise_q.push_back(known ? noise : predict_noise(x, y));
            samples_sent++;
        end
    endtask

    task automatic write_reg(cfg_reg_t r, logic [15:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= r;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        case (r)
            REG_OCT_COUNT:  octaves_reg = v[3:0];
            REG_ROUGHNESS:  rough_reg   = v;
            REG_BASE_SCALE: scale_reg   = v;
            default: ;
        endcase
    endtask

    // Let the block go idle before touching its registers
    task automatic drain();
        s_tvalid <= 1'b0;
        while (noise_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic random_items(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(9) == 0)
                send_item(OPC_LOAD, 8'($urandom), 8'($urandom), 16'($urandom),
                          16'($urandom), 0, '0);
            else if ($urandom_range(7) == 0)
                send_item(OPC_SAMPLE, 8'($urandom), 8'($urandom),
                          $urandom_range(1) ? 16'h7fff : 16'h8000,
                          $urandom_range(1) ? 16'h7fff : 16'h8000, 0, '0);
            else if ($urandom_range(1))
                send_item(OPC_SAMPLE, 8'($urandom), 8'($urandom),
                          16'($urandom_range(0, 511) - 256),
                          16'($urandom_range(0, 511) - 256), 0, '0);
            else
                send_item(OPC_SAMPLE, 8'($urandom), 8'($urandom), 16'($urandom),
                          16'($urandom), 0, '0);
        end
    endtask

    stim_row_t directed [14] = '{
        '{OPC_SAMPLE, 8'h00, 8'h00, 16'h0000, 16'h0000, 1, 16'h0000},
        '{OPC_SAMPLE, 8'hff, 8'hff, 16'h0000, 16'h0000, 1, 16'h0000},
        '{OPC_SAMPLE, 8'h00, 8'h00, 16'h7fff, 16'h7fff, 0, 16'h0000},
        '{OPC_SAMPLE, 8'h00, 8'h00, 16'h8000, 16'h8000, 0, 16'h0000},
        '{OPC_SAMPLE, 8'h00, 8'h00, 16'h7fff, 16'h8000, 0, 16'h0000},
        '{OPC_SAMPLE, 8'h00, 8'h00, 16'h8000, 16'h7fff, 0, 16'h0000},
        '{OPC_SAMPLE, 8'h00, 8'h00, 16'hffff, 16'h0001, 0, 16'h0000},
        '{OPC_SAMPLE, 8'h00, 8'h00, 16'h0001, 16'hffff, 0, 16'h0000},
        '{OPC_SAMPLE, 8'h00, 8'h00, 16'h0064, 16'h00c8, 0, 16'h0000},
        '{OPC_LOAD,   8'h00, 8'hff, 16'hffff, 16'hffff, 0, 16'h0000},
        '{OPC_LOAD,   8'hff, 8'h00, 16'h0000, 16'h0000, 0, 16'h0000},
        '{OPC_SAMPLE, 8'hff, 8'hff, 16'h0032, 16'hffce, 0, 16'h0000},
        '{OPC_SAMPLE, 8'h00, 8'h00, 16'hff38, 16'hff9c, 0, 16'h0000},
        '{OPC_SAMPLE, 8'h00, 8'h00, 16'h1234, 16'hedcb, 0, 16'h0000}
    };

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = REG_OCT_COUNT;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tuser     = OPC_LOAD;
        s_tdata     = '0;
        octaves_reg = 4'd1;
        rough_reg   = 16'd32768;
        scale_reg   = 16'd655;
        err_count   = 0;
        no_idle     = 1'b0;
        hold_req    = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fill the whole table before any sample, corner bytes at the extremes
        for (int e = 0; e < TABLE_DEPTH; e++)
            send_item(OPC_LOAD, e[7:0], (e == 1) ? 8'hff : (e == 2) ? 8'h00 : 8'($urandom),
                      16'($urandom), 16'($urandom), 0, '0);

        // Directed rows under reset settings, then with extreme settings
        foreach (directed[r])
            send_item(directed[r].opc, directed[r].idx, directed[r].val, directed[r].x,
                      directed[r].y, directed[r].known, directed[r].noise);
        drain();
        write_reg(REG_OCT_COUNT, 16'd0);
        write_reg(REG_ROUGHNESS, 16'd0);
        write_reg(REG_BASE_SCALE, 16'd0);
        send_item(OPC_SAMPLE, 8'h00, 8'h00, 16'h7fff, 16'h8000, 1, 16'h0000);
        random_items(30);
        drain();
        write_reg(REG_OCT_COUNT, 16'd15);
        write_reg(REG_ROUGHNESS, 16'd65535);
        write_reg(REG_BASE_SCALE, 16'd65535);
        random_items(RANDOM_PHASE);
        drain();

        // Back up the result side so the input stalls
        write_reg(REG_OCT_COUNT, 16'd8);
        write_reg(REG_ROUGHNESS, 16'd32768);
        write_reg(REG_BASE_SCALE, 16'd1);
        hold_req = 1'b1;
        random_items(RANDOM_PHASE);
        drain();

        for (int p = 0; p < 3; p++) begin
            write_reg(REG_OCT_COUNT, 16'($urandom_range(1, 8)));
            write_reg(REG_ROUGHNESS, 16'($urandom));
            write_reg(REG_BASE_SCALE, 16'($urandom_range(1, 4000)));
            random_items(RANDOM_PHASE);
            drain();
        end

        // Final stretch at full rate on both sides
        no_idle = 1'b1;
        write_reg(REG_OCT_COUNT, 16'd1);
        write_reg(REG_BASE_SCALE, 16'd655);
        random_items(RANDOM_PHASE);
        drain();

        $display("Sent %0d table loads and %0d samples, checked %0d results", loads_sent,
                 samples_sent, results_seen);
        $display("Covered octave counts 0..15, roughness and scale extremes, input backpressure");
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
